FILE: rtl/core/atdf_pkg.sv
// ----------------------------------------------------------------------------
// ADC temperature display formatter package
// Shared widths, scaling constants, character codes, types and the digit
// split helpers for the temperature display formatter.
// ----------------------------------------------------------------------------
package atdf_pkg;

  // Widths and counts.
  localparam int SAMPLE_W   = 10;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 5;
  localparam int LINE_LEN   = 7;
  localparam int NUM_CHARS  = 14;
  localparam int IDX_W      = 4;
  localparam int NUM_STAGES = 8;

  // Celsius scaling: tenths = floor(sample * 2000 / 1023).
  // The estimate uses 2050 / 2^21 as the reciprocal of 1023 and is folded with
  // the factor 2000, so the estimate is the exact quotient or one below it.
  localparam logic [21:0] CEL_RECIP = 22'd4100000;
  localparam logic [10:0] CEL_MUL   = 11'd2000;
  localparam logic [9:0]  CEL_DIV   = 10'd1023;

  // Fahrenheit scaling: tenths = floor(celsius * 9 / 5) + 320.
  // The estimate uses 13107 / 2^16 as the reciprocal of 5.
  localparam logic [3:0]  FAHR_MUL    = 4'd9;
  localparam logic [13:0] FAHR_RECIP  = 14'd13107;
  localparam logic [2:0]  FAHR_DIV    = 3'd5;
  localparam logic [11:0] FAHR_OFFSET = 12'd320;

  // Character codes.
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DEGREE = 8'hDF;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_F      = 8'h46;

  // Display placement.
  localparam logic [COL_W-1:0] FIRST_COL  = 5'd10;
  localparam logic [COL_W-1:0] DOT_COL    = 5'd13;
  localparam logic [COL_W-1:0] DEGREE_COL = 5'd15;
  localparam logic [COL_W-1:0] LAST_COL   = 5'd16;
  localparam logic [IDX_W-1:0] ROW_SPLIT  = 4'd7;
  localparam logic [IDX_W-1:0] LAST_IDX   = 4'd13;

  typedef struct packed {
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } digits_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [9:0] rest;
  } thou_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [6:0] rest;
  } hund_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [3:0] rest;
  } tens_t;

  typedef logic [LINE_LEN-1:0][CHAR_W-1:0]  line_t;
  typedef logic [NUM_CHARS-1:0][CHAR_W-1:0] char_seq_t;

  // Thousands digit of a value below 4000 and the remainder below 1000.
  function automatic thou_t split_thou(input logic [11:0] v);
    thou_t       res;
    logic [11:0] diff;
    if (v >= 12'd3000) begin
      res.digit = 4'd3;
      diff      = v - 12'd3000;
    end else if (v >= 12'd2000) begin
      res.digit = 4'd2;
      diff      = v - 12'd2000;
    end else if (v >= 12'd1000) begin
      res.digit = 4'd1;
      diff      = v - 12'd1000;
    end else begin
      res.digit = 4'd0;
      diff      = v;
    end
    res.rest = diff[9:0];
    return res;
  endfunction

  // Hundreds digit of a value below 1000 and the remainder below 100.
  function automatic hund_t split_hund(input logic [9:0] v);
    hund_t      res;
    logic [9:0] base;
    logic [9:0] diff;
    res.digit = 4'd0;
    base      = 10'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 10'(k * 100)) begin
        res.digit = 4'(k);
        base      = 10'(k * 100);
      end
    end
    diff     = v - base;
    res.rest = diff[6:0];
    return res;
  endfunction

  // Tens digit of a value below 100 and the units digit.
  function automatic tens_t split_tens(input logic [6:0] v);
    tens_t      res;
    logic [6:0] base;
    logic [6:0] diff;
    res.digit = 4'd0;
    base      = 7'd0;
    for (int k = 1; k < 10; k++) begin
      if (v >= 7'(k * 10)) begin
        res.digit = 4'(k);
        base      = 7'(k * 10);
      end
    end
    diff     = v - base;
    res.rest = diff[3:0];
    return res;
  endfunction

  // One display line: leading zeros of the hundreds and tens become spaces.
  function automatic line_t make_line(input digits_t d, input logic [7:0] unit);
    line_t ln;
    ln[0] = (d.d3 != 4'd0) ? CH_ZERO + {4'd0, d.d3} : CH_SPACE;
    ln[1] = (d.d3 != 4'd0 || d.d2 != 4'd0) ? CH_ZERO + {4'd0, d.d2} : CH_SPACE;
    ln[2] = CH_ZERO + {4'd0, d.d1};
    ln[3] = CH_DOT;
    ln[4] = CH_ZERO + {4'd0, d.d0};
    ln[5] = CH_DEGREE;
    ln[6] = unit;
    return ln;
  endfunction

endpackage

FILE: rtl/core/adc_temperature_display_formatter.sv
// ----------------------------------------------------------------------------
// ADC temperature display formatter
// Scales a 10-bit converter sample to Celsius and Fahrenheit tenths and emits
// the two seven-character display lines as fourteen character beats.
// ----------------------------------------------------------------------------
// Each accepted sample yields fourteen character beats, the Celsius line on
// row 0 and then the Fahrenheit line on row 1, columns 10 to 16, with
// last_char set on the fourteenth. The arithmetic runs in an eight-stage
// pipeline that takes a new sample in any cycle it has room; the character
// serializer after it sends one beat per cycle while out_stall is low, and
// loads the next sample only as the last beat of the current one is taken.
// Reset clears all valid state.
module adc_temperature_display_formatter
  import atdf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_adc_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_char_code,
  output logic                out_row,
  output logic [COL_W-1:0]    out_column,
  output logic                out_last_char
);

  // Pipeline control: a stage takes new data when it is empty or moves on.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   go;
  logic                  ser_load;

  always_comb begin
    go[NUM_STAGES] = ser_load;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign in_stall = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (go[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: scaled sample and Celsius quotient estimate.
  logic [31:0] s1_prod;
  logic [20:0] s1_x_nxt;
  logic [20:0] s1_x_r;
  logic [10:0] s1_q_r;

  assign s1_prod  = {22'd0, in_adc_sample} * {10'd0, CEL_RECIP};
  assign s1_x_nxt = {11'd0, in_adc_sample} * {10'd0, CEL_MUL};

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_x_r <= s1_x_nxt;
      s1_q_r <= s1_prod[31:21];
    end
  end

  // Stage 2: correct the estimate by one remainder compare.
  logic [20:0] s2_qm;
  logic [20:0] s2_rem;
  logic [10:0] s2_c_nxt;
  logic [10:0] s2_c_r;

  assign s2_qm    = {s1_q_r, 10'd0} - {10'd0, s1_q_r};
  assign s2_rem   = s1_x_r - s2_qm;
  assign s2_c_nxt = s1_q_r + {10'd0, (s2_rem >= {11'd0, CEL_DIV})};

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2_c_r <= s2_c_nxt;
    end
  end

  // Stage 3: Celsius times nine.
  logic [14:0] s3_y_nxt;
  logic [14:0] s3_y_r;
  logic [10:0] s3_c_r;

  assign s3_y_nxt = {4'd0, s2_c_r} * {11'd0, FAHR_MUL};

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s3_y_r <= s3_y_nxt;
      s3_c_r <= s2_c_r;
    end
  end

  // Stage 4: quotient estimate of the division by five.
  logic [28:0] s4_prod;
  logic [11:0] s4_fe_r;
  logic [14:0] s4_y_r;
  logic [10:0] s4_c_r;

  assign s4_prod = {14'd0, s3_y_r} * {15'd0, FAHR_RECIP};

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s4_fe_r <= s4_prod[27:16];
      s4_y_r  <= s3_y_r;
      s4_c_r  <= s3_c_r;
    end
  end

  // Stage 5: correct the quotient and add the Fahrenheit offset.
  logic [14:0] s5_fm;
  logic [14:0] s5_rem;
  logic [11:0] s5_f_nxt;
  logic [11:0] s5_f_r;
  logic [11:0] s5_c_r;

  assign s5_fm    = {3'd0, s4_fe_r} * {12'd0, FAHR_DIV};
  assign s5_rem   = s4_y_r - s5_fm;
  assign s5_f_nxt = s4_fe_r + {11'd0, (s5_rem >= {12'd0, FAHR_DIV})} + FAHR_OFFSET;

  always_ff @(posedge clk) begin
    if (go[4]) begin
      s5_f_r <= s5_f_nxt;
      s5_c_r <= {1'b0, s4_c_r};
    end
  end

  // Stage 6: thousands digits.
  thou_t s6_ct_r;
  thou_t s6_ft_r;

  always_ff @(posedge clk) begin
    if (go[5]) begin
      s6_ct_r <= split_thou(s5_c_r);
      s6_ft_r <= split_thou(s5_f_r);
    end
  end

  // Stage 7: hundreds digits.
  logic [3:0] s7_cd3_r;
  logic [3:0] s7_fd3_r;
  hund_t      s7_ch_r;
  hund_t      s7_fh_r;

  always_ff @(posedge clk) begin
    if (go[6]) begin
      s7_cd3_r <= s6_ct_r.digit;
      s7_fd3_r <= s6_ft_r.digit;
      s7_ch_r  <= split_hund(s6_ct_r.rest);
      s7_fh_r  <= split_hund(s6_ft_r.rest);
    end
  end

  // Stage 8: tens and units digits, then the fourteen characters.
  tens_t     s8_ct;
  tens_t     s8_ft;
  digits_t   s8_cd;
  digits_t   s8_fd;
  char_seq_t s8_chars_r;

  always_comb begin
    s8_ct    = split_tens(s7_ch_r.rest);
    s8_ft    = split_tens(s7_fh_r.rest);
    s8_cd.d3 = s7_cd3_r;
    s8_cd.d2 = s7_ch_r.digit;
    s8_cd.d1 = s8_ct.digit;
    s8_cd.d0 = s8_ct.rest;
    s8_fd.d3 = s7_fd3_r;
    s8_fd.d2 = s7_fh_r.digit;
    s8_fd.d1 = s8_ft.digit;
    s8_fd.d0 = s8_ft.rest;
  end

  always_ff @(posedge clk) begin
    if (go[7]) begin
      s8_chars_r <= {make_line(s8_fd, CH_F), make_line(s8_cd, CH_C)};
    end
  end

  // Serializer: holds one sample's characters and steps through them.
  logic                 ser_vld_r;
  logic [IDX_W-1:0]     ser_idx_r;
  char_seq_t            ser_chars_r;
  logic                 beat_take;
  logic                 ser_last;
  logic                 ser_row;
  logic [IDX_W-1:0]     ser_pos;

  assign beat_take = ser_vld_r && (!out_valid || !out_stall);
  assign ser_last  = (ser_idx_r == LAST_IDX);
  assign ser_load  = !ser_vld_r || (beat_take && ser_last);
  assign ser_row   = (ser_idx_r >= ROW_SPLIT);
  assign ser_pos   = ser_row ? ser_idx_r - ROW_SPLIT : ser_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      ser_idx_r <= '0;
    end else if (ser_load) begin
      ser_vld_r <= vld_r[NUM_STAGES-1];
      ser_idx_r <= '0;
    end else if (beat_take) begin
      ser_idx_r <= ser_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_chars_r <= s8_chars_r;
    end
  end

  // Output register: one character beat, held while stalled.
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take) begin
      out_char_r <= ser_chars_r[ser_idx_r];
      out_row_r  <= ser_row;
      out_col_r  <= FIRST_COL + {1'b0, ser_pos};
      out_last_r <= ser_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_row       = out_row_r;
  assign out_column    = out_col_r;
  assign out_last_char = out_last_r;

endmodule

FILE: rtl/core/atdf_checker.sv
// ----------------------------------------------------------------------------
// ADC temperature display formatter checker
// Port-level assertions on the character beats, bound to the top level.
// ----------------------------------------------------------------------------
module atdf_checker
  import atdf_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [SAMPLE_W-1:0] in_adc_sample,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CHAR_W-1:0]   out_char_code,
  input logic                out_row,
  input logic [COL_W-1:0]    out_column,
  input logic                out_last_char
);

  // A stalled sample beat stays on the input port unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_adc_sample))
    else $error("stalled input beat changed");

  // A stalled beat stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) &&
    $stable(out_row) && $stable(out_column) && $stable(out_last_char))
    else $error("stalled output beat changed");

  // The final beat of a run is the unit letter of the Fahrenheit line.
  a_last_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |->
    out_row && out_column == LAST_COL && out_char_code == CH_F)
    else $error("last beat at the wrong place");

  // The decimal point and the degree sign sit at fixed columns.
  a_fixed_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column != DOT_COL || out_char_code == CH_DOT) &&
    (out_column != DEGREE_COL || out_char_code == CH_DEGREE))
    else $error("fixed character missing");

  // Celsius never reaches three hundred degrees.
  a_cel_hundreds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row && out_column == FIRST_COL |->
    out_char_code == CH_SPACE || out_char_code == CH_ONE ||
    out_char_code == CH_TWO)
    else $error("Celsius hundreds digit out of range");

endmodule

bind adc_temperature_display_formatter atdf_checker u_atdf_checker (.*);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Temperature display formatter testbench
// Feeds converter samples through the formatter in bursts while the
// character side stalls on its own pattern. Every sample is converted
// locally into its fourteen expected display characters, and each character
// beat is compared field by field, in order, against those expectations.
// ----------------------------------------------------------------------------
module testbench
  import atdf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One expected display character.
  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              row;
    logic [COL_W-1:0]  column;
    logic              last_char;
  } disp_char_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_adc_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CHAR_W-1:0]   out_char_code;
  logic                out_row;
  logic [COL_W-1:0]    out_column;
  logic                out_last_char;

  logic [SAMPLE_W-1:0] sample_q[$];
  disp_char_t          char_expect_q[$];

  int unsigned samples_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned blanked_lines = 0;
  int unsigned error_count = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_phase_left = 0;
  int unsigned stall_run_left = 0;

  adc_temperature_display_formatter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_last_char (out_last_char)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue the seven characters of one line for a value in tenths.
  function automatic void queue_line(input int unsigned tenths, input logic row,
                                     input logic [CHAR_W-1:0] unit,
                                     input int unsigned first_idx);
    int unsigned       hundreds;
    int unsigned       tens;
    int unsigned       units;
    int unsigned       frac;
    logic [CHAR_W-1:0] glyph[LINE_LEN];
    disp_char_t        dc;
    hundreds = (tenths / 1000) % 10;
    tens     = (tenths / 100) % 10;
    units    = (tenths / 10) % 10;
    frac     = tenths % 10;
    // Leading zeros of the hundreds and tens of degrees are blanked.
    glyph[0] = (hundreds != 0) ? CH_ZERO + 8'(hundreds) : CH_SPACE;
    glyph[1] = (hundreds != 0 || tens != 0) ? CH_ZERO + 8'(tens) : CH_SPACE;
    glyph[2] = CH_ZERO + 8'(units);
    glyph[3] = CH_DOT;
    glyph[4] = CH_ZERO + 8'(frac);
    glyph[5] = CH_DEGREE;
    glyph[6] = unit;
    if (hundreds == 0) blanked_lines++;
    for (int k = 0; k < LINE_LEN; k++) begin
      dc.char_code = glyph[k];
      dc.row       = row;
      dc.column    = FIRST_COL + COL_W'(k);
      dc.last_char = (first_idx + k == NUM_CHARS - 1);
      char_expect_q.push_back(dc);
    end
  endfunction

  // Convert one sample to Celsius and Fahrenheit tenths and queue both lines.
  function automatic void queue_display_chars(input logic [SAMPLE_W-1:0] sample);
    int unsigned celsius;
    int unsigned fahrenheit;
    celsius    = (int'(sample) * 200000) / 102300;
    fahrenheit = celsius * 180 / 100 + 320;
    queue_line(celsius, 1'b0, CH_C, 0);
    queue_line(fahrenheit, 1'b1, CH_F, LINE_LEN);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_adc_sample <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        queue_display_chars(in_adc_sample);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
          in_valid      <= 1'b1;
          in_adc_sample <= sample_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Character side stall: phases of no stall, random stall and long runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       <= stall_mode_t'($urandom_range(0, 2));
        stall_phase_left <= $urandom_range(64, 256);
      end else begin
        stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (stall_run_left == 0) begin
            out_stall      <= ~out_stall;
            stall_run_left <= $urandom_range(1, 12);
          end else begin
            stall_run_left <= stall_run_left - 1;
          end
        end
      endcase
    end
  end

  // Character monitor: compare each beat with the oldest expectation.
  always @(posedge clk) begin
    disp_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (char_expect_q.size() == 0) begin
        $display("%0t: unexpected character beat, expected none, got %0h row %0d col %0d",
                 $realtime, out_char_code, out_row, out_column);
        error_count++;
      end else begin
        want = char_expect_q.pop_front();
        check_field("char_code", want.char_code, out_char_code);
        check_field("row", want.row, out_row);
        check_field("column", want.column, out_column);
        check_field("last_char", want.last_char, out_last_char);
        chars_checked++;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [SAMPLE_W-1:0] directed[$];
    int unsigned         pick;
    int unsigned         total_samples;
    // Zero, full scale, single-digit and two-digit Celsius readings, the
    // hundred-degree crossing and alternating bit patterns.
    directed = '{10'd0, 10'd1023, 10'd1, 10'd5, 10'd6, 10'd50, 10'd51, 10'd52,
                 10'd100, 10'd511, 10'd512, 10'd513, 10'd1022, 10'h2AA, 10'h155,
                 10'h200, 10'h100, 10'd256, 10'd767, 10'd3};
    foreach (directed[i]) sample_q.push_back(directed[i]);
    for (int i = 0; i < 420; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) sample_q.push_back(SAMPLE_W'($urandom_range(0, 1023)));
      else if (pick < 8) sample_q.push_back(SAMPLE_W'($urandom_range(0, 60)));
      else if (pick == 8) sample_q.push_back(SAMPLE_W'($urandom_range(500, 525)));
      else sample_q.push_back(SAMPLE_W'($urandom_range(1000, 1023)));
    end
    total_samples = sample_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every character of every sample has been checked.
    while (chars_checked < total_samples * NUM_CHARS)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Converted %0d samples into %0d checked display characters.",
             samples_sent, chars_checked);
    $display("%0d lines had a blanked hundreds digit; %0d mismatches.",
             blanked_lines, error_count);
    if (error_count == 0 && char_expect_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
